// ===== hw/rtl/cmh_pkg.sv =====
`timescale 1ns / 1ps

package cmh_pkg;

  // Mode codes of an input transaction (the spare code acts as a heading sample)
  localparam logic [1:0] MODE_HEADING = 2'd0;
  localparam logic [1:0] MODE_SAMPLE  = 2'd1;
  localparam logic [1:0] MODE_LAST    = 2'd2;

  // Status codes of a result transaction
  localparam logic [1:0] STS_HEADING = 2'd0;
  localparam logic [1:0] STS_SAMPLE  = 2'd1;
  localparam logic [1:0] STS_DONE    = 2'd2;
  localparam logic [1:0] STS_FAIL    = 2'd3;

  // Reset values of the calibration state
  localparam logic signed [15:0] RAW_MAX      = 16'sh7FFF;
  localparam logic signed [15:0] RAW_MIN      = 16'sh8000;
  localparam logic signed [15:0] OFFSET_Y_RST = 16'sd10;
  localparam logic signed [15:0] OFFSET_Z_RST = -16'sd32;

  // Default scales are round(NUM / DEN * 2^F)
  localparam logic [63:0] SCALE_Y_NUM  = 64'd92;
  localparam logic [63:0] SCALE_Z_NUM  = 64'd85;
  localparam logic [63:0] SCALE_DEN    = 64'd10000;
  localparam logic [63:0] SCALE_ROUND  = 64'd5000;

  // Angle constants: HALF_TURN_32 in units of 2^-32 turn, HEADING_HALF in 2^-16 turn
  localparam logic [31:0] HALF_TURN_32 = 32'h8000_0000;
  localparam logic [15:0] HEADING_HALF = 16'h8000;
  localparam int          ATAN_LEN     = 24;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FOLD,
    ST_CHECK,
    ST_DIV_Y,
    ST_SAVE_Y,
    ST_DIV_Z,
    ST_COMMIT,
    ST_MUL_Y,
    ST_MUL_Z,
    ST_PREP,
    ST_ROT,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    DP_HOLD,
    DP_MUL_Y,
    DP_MUL_Z,
    DP_PREP,
    DP_ROT,
    DP_DIV_INIT,
    DP_DIV
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   sel_z;
  } dp_ctrl_t;

  typedef struct packed {
    logic last;
    logic zero_vec;
  } dp_stat_t;

  typedef struct packed {
    logic fold;
    logic clear;
    logic wr_off;
    logic wr_scale_y;
    logic wr_scale_z;
  } cal_ctrl_t;

  // atan(2^-i) as a fraction of a turn, 2^-32 units
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:    val = 32'h2000_0000;
      5'd1:    val = 32'h12E4_051D;
      5'd2:    val = 32'h09FB_385B;
      5'd3:    val = 32'h0511_11D4;
      5'd4:    val = 32'h028B_0D43;
      5'd5:    val = 32'h0145_D7E1;
      5'd6:    val = 32'h00A2_F61E;
      5'd7:    val = 32'h0051_7C55;
      5'd8:    val = 32'h0028_BE53;
      5'd9:    val = 32'h0014_5F2E;
      5'd10:   val = 32'h000A_2F98;
      5'd11:   val = 32'h0005_17CC;
      5'd12:   val = 32'h0002_8BE6;
      5'd13:   val = 32'h0001_45F3;
      5'd14:   val = 32'h0000_A2F9;
      5'd15:   val = 32'h0000_517C;
      5'd16:   val = 32'h0000_28BE;
      5'd17:   val = 32'h0000_145F;
      5'd18:   val = 32'h0000_0A2F;
      5'd19:   val = 32'h0000_0517;
      5'd20:   val = 32'h0000_028B;
      5'd21:   val = 32'h0000_0145;
      5'd22:   val = 32'h0000_00A2;
      5'd23:   val = 32'h0000_0051;
      default: val = 32'h0000_0000;
    endcase
    return val;
  endfunction

endpackage

// ===== hw/rtl/cmh_in_if.sv =====
`timescale 1ns / 1ps

interface cmh_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [15:0] raw_y;
  logic signed [15:0] raw_z;

  modport source (output valid, output mode, output raw_y, output raw_z, input ready);
  modport sink   (input valid, input mode, input raw_y, input raw_z, output ready);
endinterface

// ===== hw/rtl/cmh_out_if.sv =====
`timescale 1ns / 1ps

interface cmh_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        heading;
  logic [1:0]         status;
  logic signed [15:0] offset_y_now;
  logic signed [15:0] offset_z_now;

  modport source (output valid, output heading, output status, output offset_y_now,
                  output offset_z_now, input ready);
  modport sink   (input valid, input heading, input status, input offset_y_now,
                  input offset_z_now, output ready);
endinterface

// ===== hw/rtl/cmh_cal.sv =====
`timescale 1ns / 1ps

module cmh_cal import cmh_pkg::*; #(
  parameter int FRAC_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cal_ctrl_t             ctrl_i,
  input  logic signed [15:0]    raw_y_i,
  input  logic signed [15:0]    raw_z_i,
  input  logic [FRAC_BITS:0]    quotient_i,
  output logic signed [15:0]    offset_y_o,
  output logic signed [15:0]    offset_z_o,
  output logic [FRAC_BITS:0]    scale_y_o,
  output logic [FRAC_BITS:0]    scale_z_o,
  output logic [16:0]           span_y_o,
  output logic [16:0]           span_z_o,
  output logic                  span_ok_o
);

  localparam int          SCALE_W   = FRAC_BITS + 1;
  localparam logic [63:0] ONE       = 64'd1 << FRAC_BITS;
  localparam logic [63:0] SY_RST64  = (SCALE_Y_NUM * ONE + SCALE_ROUND) / SCALE_DEN;
  localparam logic [63:0] SZ_RST64  = (SCALE_Z_NUM * ONE + SCALE_ROUND) / SCALE_DEN;

  logic signed [15:0] min_y_r, max_y_r, min_z_r, max_z_r;
  logic signed [15:0] offset_y_r, offset_z_r;
  logic [FRAC_BITS:0] scale_y_r, scale_z_r;
  logic signed [16:0] sum_y, sum_z, adj_y, adj_z;
  logic signed [15:0] cand_y, cand_z;
  logic signed [17:0] span_y, span_z;

  // Midpoint truncated toward zero, then half span above it
  always_comb begin
    sum_y  = 17'(min_y_r) + 17'(max_y_r);
    sum_z  = 17'(min_z_r) + 17'(max_z_r);
    adj_y  = sum_y + {16'd0, sum_y[16]};
    adj_z  = sum_z + {16'd0, sum_z[16]};
    cand_y = adj_y[16:1];
    cand_z = adj_z[16:1];
    span_y = 18'(max_y_r) - 18'(cand_y);
    span_z = 18'(max_z_r) - 18'(cand_z);
  end

  assign span_ok_o  = !span_y[17] && (span_y != '0) && !span_z[17] && (span_z != '0);
  assign span_y_o   = span_y[16:0];
  assign span_z_o   = span_z[16:0];
  assign offset_y_o = offset_y_r;
  assign offset_z_o = offset_z_r;
  assign scale_y_o  = scale_y_r;
  assign scale_z_o  = scale_z_r;

  // Track extremes, clear them when a calibration finishes
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl_i.clear) begin
      min_y_r <= RAW_MAX;
      min_z_r <= RAW_MAX;
      max_y_r <= RAW_MIN;
      max_z_r <= RAW_MIN;
    end else if (ctrl_i.fold) begin
      if (raw_y_i < min_y_r) min_y_r <= raw_y_i;
      if (raw_y_i > max_y_r) max_y_r <= raw_y_i;
      if (raw_z_i < min_z_r) min_z_r <= raw_z_i;
      if (raw_z_i > max_z_r) max_z_r <= raw_z_i;
    end
  end

  // Hold offsets and scales in use
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_y_r <= OFFSET_Y_RST;
      offset_z_r <= OFFSET_Z_RST;
      scale_y_r  <= SCALE_W'(SY_RST64);
      scale_z_r  <= SCALE_W'(SZ_RST64);
    end else begin
      if (ctrl_i.wr_off) begin
        offset_y_r <= cand_y;
        offset_z_r <= cand_z;
      end
      if (ctrl_i.wr_scale_y) scale_y_r <= quotient_i;
      if (ctrl_i.wr_scale_z) scale_z_r <= quotient_i;
    end
  end

  a_fold_order: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_i.fold |=> (min_y_r <= max_y_r) && (min_z_r <= max_z_r))
    else $error("extremes out of order after a fold");

  a_commit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_i.wr_off |-> span_ok_o)
    else $error("offsets written with a zero span");

endmodule

// ===== hw/rtl/cmh_dp.sv =====
`timescale 1ns / 1ps

module cmh_dp import cmh_pkg::*; #(
  parameter int FRAC_BITS = 24,
  parameter int STEPS     = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_ctrl_t              ctrl_i,
  input  logic signed [15:0]    raw_y_i,
  input  logic signed [15:0]    raw_z_i,
  input  logic signed [15:0]    offset_y_i,
  input  logic signed [15:0]    offset_z_i,
  input  logic [FRAC_BITS:0]    scale_y_i,
  input  logic [FRAC_BITS:0]    scale_z_i,
  input  logic [16:0]           span_y_i,
  input  logic [16:0]           span_z_i,
  output logic [FRAC_BITS:0]    quotient_o,
  output logic [15:0]           heading_o,
  output dp_stat_t              stat_o
);

  localparam int PW     = FRAC_BITS + 19;
  localparam int CW     = FRAC_BITS + 20;
  localparam int MAXIT  = (FRAC_BITS + 1 > STEPS) ? FRAC_BITS + 1 : STEPS;
  localparam int CNT_W  = $clog2(MAXIT);

  logic signed [16:0]   diff_y, diff_z, mul_a;
  logic [FRAC_BITS:0]   mul_b;
  logic [16:0]          divisor;
  logic signed [PW-1:0] prod;
  logic signed [CW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [CW-1:0] sh_x, sh_y, ya, yb, y_sum, x_sum, div_ya;
  logic [31:0]          ang_r, ang_nxt, atan_val;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 is_div, y_neg, y_sub, q_bit;

  // One multiplier, Y axis then Z axis
  always_comb begin
    diff_y = 17'(raw_y_i) - 17'(offset_y_i);
    diff_z = 17'(raw_z_i) - 17'(offset_z_i);
    mul_a  = (ctrl_i.op == DP_MUL_Z) ? diff_z : diff_y;
    mul_b  = (ctrl_i.op == DP_MUL_Z) ? scale_z_i : scale_y_i;
    prod   = mul_a * $signed({1'b0, mul_b});
  end

  // Shared shift-add unit: CORDIC step or restoring divide step
  always_comb begin
    is_div   = (ctrl_i.op == DP_DIV);
    y_neg    = y_r[CW-1];
    divisor  = ctrl_i.sel_z ? span_z_i : span_y_i;
    sh_x     = x_r >>> cnt_r;
    sh_y     = y_r >>> cnt_r;
    div_ya   = {y_r[CW-2:0], (cnt_r == '0)};
    ya       = is_div ? div_ya : y_r;
    yb       = is_div ? CW'(divisor) : sh_x;
    y_sub    = is_div || !y_neg;
    y_sum    = y_sub ? ya - yb : ya + yb;
    x_sum    = y_neg ? x_r - sh_y : x_r + sh_y;
    q_bit    = !y_sum[CW-1];
    atan_val = atan_turn(5'(cnt_r));
  end

  always_comb begin
    x_nxt   = x_r;
    y_nxt   = y_r;
    ang_nxt = ang_r;
    cnt_nxt = cnt_r;
    case (ctrl_i.op)
      DP_MUL_Y: y_nxt = CW'(prod);
      DP_MUL_Z: x_nxt = CW'(prod);
      DP_PREP: begin
        // x holds the Z product; the true x is its negation
        cnt_nxt = '0;
        if (!x_r[CW-1] && (x_r != '0)) begin
          y_nxt   = -y_r;
          ang_nxt = HALF_TURN_32;
        end else begin
          x_nxt   = -x_r;
          ang_nxt = '0;
        end
      end
      DP_ROT: begin
        x_nxt   = x_sum;
        y_nxt   = y_sum;
        ang_nxt = y_neg ? ang_r - atan_val : ang_r + atan_val;
        cnt_nxt = cnt_r + 1'b1;
      end
      DP_DIV_INIT: begin
        x_nxt   = '0;
        y_nxt   = '0;
        cnt_nxt = '0;
      end
      DP_DIV: begin
        y_nxt   = q_bit ? y_sum : div_ya;
        x_nxt   = {x_r[CW-2:0], q_bit};
        cnt_nxt = cnt_r + 1'b1;
      end
      default: begin
        x_nxt = x_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    ang_r <= ang_nxt;
  end

  // Round the turn fraction to 16 bits, wrapping at a full turn
  assign heading_o       = ang_r[31:16] + {15'd0, ang_r[15]};
  assign quotient_o      = x_r[FRAC_BITS:0];
  assign stat_o.zero_vec = (x_r == '0) && (y_r == '0);
  assign stat_o.last     = (ctrl_i.op == DP_ROT) ? (cnt_r == CNT_W'(STEPS - 1))
                                                 : (cnt_r == CNT_W'(FRAC_BITS));

endmodule

// ===== hw/rtl/compass_minmax_calibration_heading.sv =====
// Heading sample: MUL_Y, MUL_Z, PREP, the ROT steps and OUT, or PREP straight to OUT
// when both axis terms are zero. Calibration sample: FOLD, then OUT; last sample: FOLD,
// CHECK, the Y divide, SAVE_Y, the Z divide, COMMIT and OUT, or FOLD, CHECK and OUT on
// a zero span. One item at a time: the CORDIC and divider share one shift-add unit
// stepped once per cycle; the next item is taken after the result is registered.
// Synchronous active-low reset restores default offsets, scales and full-range extremes.
`timescale 1ns / 1ps

module compass_minmax_calibration_heading import cmh_pkg::*; #(
  parameter int SCALE_FRACTION_BITS = 24,
  parameter int ANGLE_STEPS         = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  cmh_in_if.sink     in_ch,
  cmh_out_if.source  out_ch
);

  localparam int SW = SCALE_FRACTION_BITS + 1;

  state_t             state_r, state_nxt;
  logic [1:0]         mode_r, sts_r;
  logic signed [15:0] ry_r, rz_r;
  logic               zero_r;
  logic               out_valid_r;
  logic [15:0]        hdg_o_r;
  logic [1:0]         sts_o_r;
  logic signed [15:0] offy_o_r, offz_o_r;
  logic               in_acc, out_load;

  dp_ctrl_t           dp_ctrl;
  dp_stat_t           dp_stat;
  cal_ctrl_t          cal_ctrl;
  logic signed [15:0] offset_y, offset_z;
  logic [SW-1:0]      scale_y, scale_z, quotient;
  logic [16:0]        span_y, span_z;
  logic               span_ok;
  logic [15:0]        dp_heading;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);

  cmh_cal #(
    .FRAC_BITS (SCALE_FRACTION_BITS)
  ) u_cal (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl_i     (cal_ctrl),
    .raw_y_i    (ry_r),
    .raw_z_i    (rz_r),
    .quotient_i (quotient),
    .offset_y_o (offset_y),
    .offset_z_o (offset_z),
    .scale_y_o  (scale_y),
    .scale_z_o  (scale_z),
    .span_y_o   (span_y),
    .span_z_o   (span_z),
    .span_ok_o  (span_ok)
  );

  cmh_dp #(
    .FRAC_BITS (SCALE_FRACTION_BITS),
    .STEPS     (ANGLE_STEPS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl_i     (dp_ctrl),
    .raw_y_i    (ry_r),
    .raw_z_i    (rz_r),
    .offset_y_i (offset_y),
    .offset_z_i (offset_z),
    .scale_y_i  (scale_y),
    .scale_z_i  (scale_z),
    .span_y_i   (span_y),
    .span_z_i   (span_z),
    .quotient_o (quotient),
    .heading_o  (dp_heading),
    .stat_o     (dp_stat)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.mode inside {MODE_SAMPLE, MODE_LAST}) state_nxt = ST_FOLD;
          else                                            state_nxt = ST_MUL_Y;
        end
      end
      ST_FOLD:   state_nxt = (mode_r == MODE_LAST) ? ST_CHECK : ST_OUT;
      ST_CHECK:  state_nxt = span_ok ? ST_DIV_Y : ST_OUT;
      ST_DIV_Y:  state_nxt = dp_stat.last ? ST_SAVE_Y : ST_DIV_Y;
      ST_SAVE_Y: state_nxt = ST_DIV_Z;
      ST_DIV_Z:  state_nxt = dp_stat.last ? ST_COMMIT : ST_DIV_Z;
      ST_COMMIT: state_nxt = ST_OUT;
      ST_MUL_Y:  state_nxt = ST_MUL_Z;
      ST_MUL_Z:  state_nxt = ST_PREP;
      ST_PREP:   state_nxt = dp_stat.zero_vec ? ST_OUT : ST_ROT;
      ST_ROT:    state_nxt = dp_stat.last ? ST_OUT : ST_ROT;
      ST_OUT:    state_nxt = out_load ? ST_IDLE : ST_OUT;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer
  always_comb begin
    dp_ctrl  = '{op: DP_HOLD, sel_z: 1'b0};
    cal_ctrl = '0;
    in_ch.ready = 1'b0;
    case (state_r)
      ST_IDLE:   in_ch.ready = 1'b1;
      ST_FOLD:   cal_ctrl.fold = 1'b1;
      ST_CHECK: begin
        if (span_ok) dp_ctrl.op = DP_DIV_INIT;
        else         cal_ctrl.clear = 1'b1;
      end
      ST_DIV_Y:  dp_ctrl.op = DP_DIV;
      ST_SAVE_Y: begin
        cal_ctrl.wr_scale_y = 1'b1;
        dp_ctrl.op          = DP_DIV_INIT;
      end
      ST_DIV_Z:  dp_ctrl = '{op: DP_DIV, sel_z: 1'b1};
      ST_COMMIT: begin
        cal_ctrl.wr_scale_z = 1'b1;
        cal_ctrl.wr_off     = 1'b1;
        cal_ctrl.clear      = 1'b1;
      end
      ST_MUL_Y:  dp_ctrl.op = DP_MUL_Y;
      ST_MUL_Z:  dp_ctrl.op = DP_MUL_Z;
      ST_PREP:   dp_ctrl.op = DP_PREP;
      ST_ROT:    dp_ctrl.op = DP_ROT;
      default:   dp_ctrl.op = DP_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Latch the accepted transaction
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= in_ch.mode;
      ry_r   <= in_ch.raw_y;
      rz_r   <= in_ch.raw_z;
    end
  end

  // Track result status of the item in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sts_r  <= STS_HEADING;
      zero_r <= 1'b0;
    end else begin
      if (in_acc) begin
        sts_r  <= (in_ch.mode inside {MODE_SAMPLE, MODE_LAST}) ? STS_SAMPLE : STS_HEADING;
        zero_r <= 1'b0;
      end else if ((state_r == ST_CHECK) && !span_ok) begin
        sts_r <= STS_FAIL;
      end else if (state_r == ST_COMMIT) begin
        sts_r <= STS_DONE;
      end
      if (state_r == ST_PREP) zero_r <= dp_stat.zero_vec;
    end
  end

  // Output register: load when free or being drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (sts_r == STS_HEADING) hdg_o_r <= zero_r ? HEADING_HALF : dp_heading;
      else                      hdg_o_r <= '0;
      sts_o_r  <= sts_r;
      offy_o_r <= offset_y;
      offz_o_r <= offset_z;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.heading      = hdg_o_r;
  assign out_ch.status       = sts_o_r;
  assign out_ch.offset_y_now = offy_o_r;
  assign out_ch.offset_z_now = offz_o_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != ST_IDLE))
    else $error("sequencer idle right after a transaction");

  a_cal_heading_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (sts_o_r != STS_HEADING)) |-> (hdg_o_r == '0))
    else $error("calibration result carries a heading");

  a_fail_keeps_offsets: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_CHECK) && !span_ok) |=> ($stable(offset_y) && $stable(offset_z)))
    else $error("offsets changed on a failed calibration");

  a_rot_heading_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROT) |-> (sts_r == STS_HEADING))
    else $error("angle unit running for a calibration item");

endmodule

// ===== dv/compass_minmax_calibration_heading_tb.sv =====
`timescale 1ns / 1ps

module compass_minmax_calibration_heading_tb;
  import cmh_pkg::*;

  localparam int         CLK_PERIOD   = 12;
  localparam int         SCALE_FRAC   = 24;
  localparam int         ANGLE_STEPS  = 16;
  localparam int         LIMIT_CYCLES = 400000;
  localparam int         DRAIN_CYCLES = 20000;
  localparam int         SETTLE_CYCLES = 80;
  localparam logic [1:0] MODE_SPARE   = 2'd3;
  localparam longint     SCALE_ONE    = longint'(1) << SCALE_FRAC;
  localparam longint     SCALE_MASK   = (SCALE_ONE << 1) - 1;
  localparam logic [31:0] ROUND_HALF  = 32'h0000_8000;

  // atan(2^-i) in 2^-32 turn units
  localparam logic [31:0] ATAN_TURNS [0:23] = '{
    32'h2000_0000, 32'h12E4_051D, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2E, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9, 32'h0000_517C,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A2F, 32'h0000_0517,
    32'h0000_028B, 32'h0000_0145, 32'h0000_00A2, 32'h0000_0051
  };

  typedef struct packed {
    logic [15:0] heading;
    logic [1:0]  status;
    logic [15:0] offset_y;
    logic [15:0] offset_z;
  } fix_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  cmh_in_if  in_ch ();
  cmh_out_if out_ch ();

  compass_minmax_calibration_heading #(
    .SCALE_FRACTION_BITS(SCALE_FRAC),
    .ANGLE_STEPS        (ANGLE_STEPS)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Calibration tracking of the predictor
  int     cal_min_y, cal_max_y, cal_min_z, cal_max_z;
  int     off_y, off_z;
  longint scale_y, scale_z;

  fix_t expected_fixes[$];
  int   mismatch_count = 0;
  int   readings_sent  = 0;
  bit   idling_on      = 1'b1;

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic void clear_extremes();
    cal_min_y = RAW_MAX;
    cal_min_z = RAW_MAX;
    cal_max_y = RAW_MIN;
    cal_max_z = RAW_MIN;
  endfunction

  // Remove offsets, apply scales and run the vectoring CORDIC
  function automatic logic [15:0] predict_heading(input logic signed [15:0] ry,
                                                  input logic signed [15:0] rz);
    longint      yv, xv, dx, dy;
    logic [31:0] ang, rounded;
    yv  = (longint'(ry) - off_y) * scale_y;
    xv  = -((longint'(rz) - off_z) * scale_z);
    ang = '0;
    if (xv == 0 && yv == 0) return HEADING_HALF;
    // fold the left half plane over by half a turn
    if (xv < 0) begin
      xv  = -xv;
      yv  = -yv;
      ang = HALF_TURN_32;
    end
    for (int i = 0; i < ANGLE_STEPS && i < ATAN_LEN; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv >= 0) begin
        xv  = xv + dx;
        yv  = yv - dy;
        ang = ang + ATAN_TURNS[i];
      end else begin
        xv  = xv - dx;
        yv  = yv + dy;
        ang = ang - ATAN_TURNS[i];
      end
    end
    rounded = ang + ROUND_HALF;
    return rounded[31:16];
  endfunction

  // Advance the calibration state by one reading and build its result
  function automatic fix_t predict_fix(input logic [1:0] mode,
                                       input logic signed [15:0] ry,
                                       input logic signed [15:0] rz);
    fix_t fix;
    int   y, z, oy, oz, sy, sz;
    y = ry;
    z = rz;
    fix.heading = '0;
    if (mode == MODE_SAMPLE || mode == MODE_LAST) begin
      if (y < cal_min_y) cal_min_y = y;
      if (y > cal_max_y) cal_max_y = y;
      if (z < cal_min_z) cal_min_z = z;
      if (z > cal_max_z) cal_max_z = z;
      fix.status = STS_SAMPLE;
      if (mode == MODE_LAST) begin
        oy = (cal_min_y + cal_max_y) / 2;
        oz = (cal_min_z + cal_max_z) / 2;
        sy = cal_max_y - oy;
        sz = cal_max_z - oz;
        // a zero span on either axis keeps the old calibration
        if (sy > 0 && sz > 0) begin
          off_y      = oy;
          off_z      = oz;
          scale_y    = (SCALE_ONE / sy) & SCALE_MASK;
          scale_z    = (SCALE_ONE / sz) & SCALE_MASK;
          fix.status = STS_DONE;
        end else begin
          fix.status = STS_FAIL;
        end
        clear_extremes();
      end
    end else begin
      fix.heading = predict_heading(ry, rz);
      fix.status  = STS_HEADING;
    end
    fix.offset_y = off_y[15:0];
    fix.offset_z = off_z[15:0];
    return fix;
  endfunction

  // Drive one reading, hold it until accepted, then maybe idle
  task automatic send_reading(input logic [1:0] mode, input int ry, input int rz);
    in_ch.valid <= 1'b1;
    in_ch.mode  <= mode;
    in_ch.raw_y <= 16'(ry);
    in_ch.raw_z <= 16'(rz);
    do @(posedge clk); while (!in_ch.ready);
    expected_fixes.push_back(predict_fix(mode, 16'(ry), 16'(rz)));
    readings_sent++;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every result is back
  task automatic wait_fixes_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_fixes.size() != 0);
  endtask

  function automatic int clamp_raw(input int v);
    if (v > RAW_MAX) return RAW_MAX;
    if (v < RAW_MIN) return RAW_MIN;
    return v;
  endfunction

  function automatic int rand_raw();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int rand_spread();
    case ($urandom_range(0, 3))
      0:       return int'($urandom_range(0, 2));
      1:       return int'($urandom_range(3, 100));
      2:       return int'($urandom_range(100, 4000));
      default: return int'($urandom_range(4000, 32767));
    endcase
  endfunction

  function automatic int rand_near(input int center, input int spread);
    return clamp_raw(center + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  // Headings at the default calibration: extremes, zero vector, spare mode
  task automatic test_default_heading();
    send_reading(MODE_HEADING, 32767, 32767);
    send_reading(MODE_HEADING, -32768, -32768);
    send_reading(MODE_HEADING, 32767, -32768);
    send_reading(MODE_HEADING, -32768, 32767);
    send_reading(MODE_HEADING, OFFSET_Y_RST, OFFSET_Z_RST);
    send_reading(MODE_HEADING, OFFSET_Y_RST, 0);
    send_reading(MODE_HEADING, OFFSET_Y_RST, -100);
    send_reading(MODE_SPARE, 500, -700);
  endtask

  // Calibrations that must fail on a zero span
  task automatic test_zero_span();
    send_reading(MODE_LAST, 1234, -4321);
    // y spans -5..-4: the offset truncates to -4, leaving no span
    send_reading(MODE_SAMPLE, -5, 200);
    send_reading(MODE_LAST, -4, 300);
    send_reading(MODE_SAMPLE, 100, 7);
    send_reading(MODE_LAST, 300, 7);
  endtask

  // Widest span on both axes, with the sender held until all results are back
  task automatic test_full_range_cal();
    wait_fixes_drained();
    send_reading(MODE_SAMPLE, -32768, 32767);
    send_reading(MODE_LAST, 32767, -32768);
    send_reading(MODE_HEADING, 32767, -32768);
    send_reading(MODE_HEADING, -32768, 32767);
  endtask

  // Unit span gives the largest scale; probe extremes and both axes
  task automatic test_unit_span_cal();
    send_reading(MODE_SAMPLE, 4, 100);
    send_reading(MODE_LAST, 5, 101);
    send_reading(MODE_HEADING, 4, 100);
    send_reading(MODE_HEADING, 32767, -32768);
    send_reading(MODE_HEADING, -32768, 32767);
    send_reading(MODE_HEADING, 4, 0);
    send_reading(MODE_HEADING, -32768, 100);
  endtask

  // Random calibration sessions followed by headings, mixed with noise
  task automatic run_calibration_sessions(input int target);
    int kind, samples, cy, cz, spy, spz;
    while (readings_sent < target) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        cy      = rand_raw();
        cz      = rand_raw();
        spy     = rand_spread();
        spz     = rand_spread();
        samples = $urandom_range(0, 5);
        repeat (samples) send_reading(MODE_SAMPLE, rand_near(cy, spy), rand_near(cz, spz));
        send_reading(MODE_LAST, rand_near(cy, spy), rand_near(cz, spz));
      end
      if (kind <= 6 || kind == 9) begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 1) == 0)
            send_reading(MODE_HEADING, rand_near(off_y, rand_spread()),
                         rand_near(off_z, rand_spread()));
          else
            send_reading(MODE_HEADING, rand_raw(), rand_raw());
        end
      end else begin
        repeat ($urandom_range(1, 5))
          send_reading(2'($urandom_range(0, 3)), rand_raw(), rand_raw());
      end
      if ($urandom_range(0, 7) == 0) wait_fixes_drained();
    end
  endtask

  // Closing stretch with no idling on either side
  task automatic test_streaming(input int count);
    idling_on = 1'b0;
    run_calibration_sessions(readings_sent + count);
  endtask

  // Stall the result channel in random bursts
  initial begin
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (idling_on && $urandom_range(0, 1) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  end

  // Compare each result transaction with the oldest expected fix
  always @(posedge clk) begin
    fix_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_fixes.size() == 0) begin
        report_mismatch($sformatf("unexpected result heading=%0d status=%0d",
                                  out_ch.heading, out_ch.status));
      end else begin
        want = expected_fixes.pop_front();
        if (out_ch.heading !== want.heading)
          report_mismatch($sformatf("heading got %0d want %0d",
                                    out_ch.heading, want.heading));
        if (out_ch.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    out_ch.status, want.status));
        if (out_ch.offset_y_now !== want.offset_y)
          report_mismatch($sformatf("offset_y_now got %0d want %0d",
                                    out_ch.offset_y_now, $signed(want.offset_y)));
        if (out_ch.offset_z_now !== want.offset_z)
          report_mismatch($sformatf("offset_z_now got %0d want %0d",
                                    out_ch.offset_z_now, $signed(want.offset_z)));
      end
    end
  end

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.mode  <= MODE_HEADING;
    in_ch.raw_y <= '0;
    in_ch.raw_z <= '0;
    clear_extremes();
    off_y   = OFFSET_Y_RST;
    off_z   = OFFSET_Z_RST;
    scale_y = longint'((SCALE_Y_NUM * SCALE_ONE + SCALE_ROUND) / SCALE_DEN) & SCALE_MASK;
    scale_z = longint'((SCALE_Z_NUM * SCALE_ONE + SCALE_ROUND) / SCALE_DEN) & SCALE_MASK;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_heading();
    test_zero_span();
    test_full_range_cal();
    test_unit_span_cal();
    run_calibration_sessions(490);
    test_streaming(60);

    // drop valid, wait for the last results, then let the block settle
    in_ch.valid <= 1'b0;
    for (int n = 0; n < DRAIN_CYCLES && expected_fixes.size() != 0; n++)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_fixes.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_fixes.size()));

    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/cmh_pkg.sv
hw/rtl/cmh_in_if.sv
hw/rtl/cmh_out_if.sv
hw/rtl/cmh_cal.sv
hw/rtl/cmh_dp.sv
hw/rtl/compass_minmax_calibration_heading.sv
dv/compass_minmax_calibration_heading_tb.sv
